// ===== sv/irpd_pkg.sv =====
// ============================================================================
// irpd_pkg
// Shared types and constants for the IR pulse-distance frame sender.
// ============================================================================
package irpd_pkg;

    localparam int CMD_BITS_DEF = 32;
    localparam int CFG_DW       = 24;
    localparam int CFG_IW       = 3;

    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_SEND = 2'd1;
    localparam logic [1:0] MODE_STOP = 2'd2;

    localparam logic [CFG_IW-1:0] CFG_HEADER_PERIOD   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_HEADER_MARK     = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_BIT_MARK        = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_ONE_PERIOD      = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_ZERO_PERIOD     = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_REPEAT_PERIOD   = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_REPEAT_INTERVAL = 3'd6;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] command_word;
    } t_in_item;

    typedef struct packed {
        logic ir_level;
        logic busy_res;
        logic frame_done;
    } t_out_item;

    typedef struct packed {
        logic [15:0] header_period;
        logic [15:0] header_mark;
        logic [15:0] bit_mark;
        logic [15:0] one_period;
        logic [15:0] zero_period;
        logic [15:0] repeat_period;
        logic [23:0] repeat_interval;
    } t_cfg;

endpackage

// ===== sv/irpd_cfg_regs.sv =====
// ============================================================================
// irpd_cfg_regs
// Timing register file, written through a plain write port.
// ============================================================================
module irpd_cfg_regs
    import irpd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_period   <= 16'd54000;
            r_cfg.header_mark     <= 16'd36000;
            r_cfg.bit_mark        <= 16'd2240;
            r_cfg.one_period      <= 16'd9000;
            r_cfg.zero_period     <= 16'd4480;
            r_cfg.repeat_period   <= 16'd44800;
            r_cfg.repeat_interval <= 24'd440320;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HEADER_PERIOD:   r_cfg.header_period   <= i_cfg_data[15:0];
                CFG_HEADER_MARK:     r_cfg.header_mark     <= i_cfg_data[15:0];
                CFG_BIT_MARK:        r_cfg.bit_mark        <= i_cfg_data[15:0];
                CFG_ONE_PERIOD:      r_cfg.one_period      <= i_cfg_data[15:0];
                CFG_ZERO_PERIOD:     r_cfg.zero_period     <= i_cfg_data[15:0];
                CFG_REPEAT_PERIOD:   r_cfg.repeat_period   <= i_cfg_data[15:0];
                CFG_REPEAT_INTERVAL: r_cfg.repeat_interval <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/irpd_engine.sv =====
// ============================================================================
// irpd_engine
// Frame sequencer: applies one tick beat to the frame state and forms the
// envelope outputs for that tick.
// ============================================================================
module irpd_engine
    import irpd_pkg::*;
#(
    parameter int COMMAND_BITS = CMD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    localparam int BPW = $clog2(COMMAND_BITS + 1);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_HEADER  = 3'd1;
    localparam logic [2:0] PH_BITS    = 3'd2;
    localparam logic [2:0] PH_RHEADER = 3'd3;
    localparam logic [2:0] PH_TRAILER = 3'd4;

    logic [2:0]              r_phase, n_phase;
    logic [BPW-1:0]          r_bit_pos, n_bit_pos;
    logic [15:0]             r_period_cnt, n_period_cnt;
    logic [COMMAND_BITS-1:0] r_cmd_shift, n_cmd_shift;
    logic [23:0]             r_rep_cnt, n_rep_cnt;
    logic                    r_rep_armed, n_rep_armed;

    logic [23:0]    rep_inc;
    logic [15:0]    len;
    logic [15:0]    mark;
    logic [16:0]    next_cnt;
    logic [BPW-1:0] bit_inc;
    logic [2:0]     cur_phase;
    logic           level, busy, done;

    always_comb begin
        n_phase      = r_phase;
        n_bit_pos    = r_bit_pos;
        n_period_cnt = r_period_cnt;
        n_cmd_shift  = r_cmd_shift;
        n_rep_cnt    = r_rep_cnt;
        n_rep_armed  = r_rep_armed;
        rep_inc      = r_rep_cnt + 24'd1;
        level        = 1'b0;
        busy         = 1'b0;
        done         = 1'b0;
        len          = 16'd1;
        mark         = 16'd0;

        if (i_item.mode == MODE_SEND) begin
            n_cmd_shift  = i_item.command_word[31 -: COMMAND_BITS];
            n_bit_pos    = '0;
            n_rep_cnt    = '0;
            n_rep_armed  = 1'b1;
            n_phase      = PH_HEADER;
            n_period_cnt = '0;
        end else begin
            if (i_item.mode == MODE_STOP) begin
                n_rep_armed = 1'b0;
            end
            if (n_rep_armed) begin
                n_rep_cnt = rep_inc;
                if (rep_inc == i_cfg.repeat_interval) begin
                    n_rep_cnt    = '0;
                    n_phase      = PH_RHEADER;
                    n_period_cnt = '0;
                end
            end
        end

        cur_phase = n_phase;
        next_cnt  = {1'b0, n_period_cnt} + 17'd1;
        bit_inc   = n_bit_pos + BPW'(1);

        unique case (cur_phase)
            PH_HEADER: begin
                len = i_cfg.header_period; mark = i_cfg.header_mark; busy = 1'b1;
            end
            PH_RHEADER: begin
                len = i_cfg.repeat_period; mark = i_cfg.header_mark; busy = 1'b1;
            end
            PH_BITS: begin
                len  = n_cmd_shift[COMMAND_BITS-1] ? i_cfg.one_period : i_cfg.zero_period;
                mark = i_cfg.bit_mark;
                busy = 1'b1;
            end
            PH_TRAILER: begin
                len = i_cfg.bit_mark; mark = i_cfg.bit_mark; busy = 1'b1;
            end
            default: ;
        endcase

        if (busy) begin
            level = (n_period_cnt < mark) || (cur_phase == PH_TRAILER);
            if (next_cnt >= {1'b0, len}) begin
                n_period_cnt = '0;
                unique case (cur_phase)
                    PH_HEADER: begin
                        n_bit_pos = '0;
                        n_phase   = PH_BITS;
                    end
                    PH_BITS: begin
                        n_cmd_shift = n_cmd_shift << 1;
                        n_bit_pos   = bit_inc;
                        n_phase     = (bit_inc >= BPW'(COMMAND_BITS)) ? PH_TRAILER : PH_BITS;
                    end
                    PH_RHEADER: n_phase = PH_TRAILER;
                    default: begin
                        done    = 1'b1;
                        n_phase = PH_IDLE;
                    end
                endcase
            end else begin
                n_period_cnt = next_cnt[15:0];
            end
        end else begin
            n_phase = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_pos    <= '0;
            r_period_cnt <= '0;
            r_cmd_shift  <= '0;
            r_rep_cnt    <= '0;
            r_rep_armed  <= 1'b0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_bit_pos    <= n_bit_pos;
            r_period_cnt <= n_period_cnt;
            r_cmd_shift  <= n_cmd_shift;
            r_rep_cnt    <= n_rep_cnt;
            r_rep_armed  <= n_rep_armed;
        end
    end

    assign o_result.ir_level   = level;
    assign o_result.busy_res   = busy;
    assign o_result.frame_done = done;

endmodule

// ===== sv/ir_pulse_distance_frame_sender_unit.sv =====
// ============================================================================
// ir_pulse_distance_frame_sender_unit
// NEC-style IR frame envelope generator, one tick beat in, one result out.
// ============================================================================
//  channel   signals                                    dir
//  in        i_in_valid / o_in_ready / i_in             tick beat in
//  out       o_out_valid / i_out_ready / o_out          envelope beat out
//  cfg       i_cfg_we / i_cfg_idx / i_cfg_data          register write
//
//  One beat per clock while the output is not stalled; a beat is registered on
//  entry, processed by the sequencer and held in the output register. The
//  sequencer advances only when the output register is free or being drained,
//  so a stalled output backs up into the input register and then drops
//  o_in_ready. Synchronous active-low reset returns the sequencer to idle and
//  the timing registers to their defaults.
// ============================================================================
module ir_pulse_distance_frame_sender_unit
    import irpd_pkg::*;
#(
    parameter int COMMAND_BITS = CMD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      step;
    t_cfg      cfg;
    t_out_item result;

    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    irpd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    irpd_engine #(
        .COMMAND_BITS (COMMAND_BITS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out_item;

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// IR pulse-distance frame sender testbench
// Drives tick, send and stop beats into the envelope generator, predicts every
// envelope beat from an internal copy of the frame sequencer and compares the
// results in order. Covers idle output, all timing registers at small and zero
// values, header/repeat at full scale, restarts, repeats, stop, output stalls.
// ----------------------------------------------------------------------------
module testbench;
    import irpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam int         CYCLE_LIMIT = 2_000_000;

    typedef enum logic [2:0] {
        PH_IDLE, PH_HEADER, PH_BITS, PH_RHEADER, PH_TRAILER
    } t_phase;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    t_in_item          in_beat   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    t_out_item         out_beat;
    logic              cfg_we    = 1'b0;
    logic [CFG_IW-1:0] cfg_idx   = '0;
    logic [CFG_DW-1:0] cfg_data  = '0;

    // sequencer copy
    t_cfg        timing;
    t_phase      seq_phase;
    logic [5:0]  bit_idx;
    logic [15:0] tick_cnt;
    logic [31:0] cmd_shift;
    logic [23:0] rep_cnt;
    logic        rep_armed;

    t_out_item envelope_q[$];
    int        mismatch_cnt = 0;
    int        cycle_cnt    = 0;
    int        hold_cycles  = 0;
    bit        idle_on      = 1'b1;

    ir_pulse_distance_frame_sender_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic t_cfg mk_timing(input int hp, input int hm, input int bm,
                                       input int one, input int zero, input int rp,
                                       input int ri);
        t_cfg c;
        c.header_period   = 16'(hp);
        c.header_mark     = 16'(hm);
        c.bit_mark        = 16'(bm);
        c.one_period      = 16'(one);
        c.zero_period     = 16'(zero);
        c.repeat_period   = 16'(rp);
        c.repeat_interval = 24'(ri);
        return c;
    endfunction

    function automatic void reset_sequencer();
        timing    = mk_timing(54000, 36000, 2240, 9000, 4480, 44800, 440320);
        seq_phase = PH_IDLE;
        bit_idx   = '0;
        tick_cnt  = '0;
        cmd_shift = '0;
        rep_cnt   = '0;
        rep_armed = 1'b0;
    endfunction

    function automatic t_out_item envelope_step(input t_in_item beat);
        t_out_item   res;
        logic [15:0] len;
        logic [15:0] mark;
        logic [16:0] nxt;
        res  = '0;
        len  = 16'd1;
        mark = 16'd0;
        if (beat.mode == MODE_SEND) begin
            cmd_shift = beat.command_word;
            bit_idx   = '0;
            rep_cnt   = '0;
            rep_armed = 1'b1;
            seq_phase = PH_HEADER;
            tick_cnt  = '0;
        end else begin
            if (beat.mode == MODE_STOP) rep_armed = 1'b0;
            if (rep_armed) begin
                rep_cnt = rep_cnt + 24'd1;
                if (rep_cnt == timing.repeat_interval) begin
                    rep_cnt   = '0;
                    seq_phase = PH_RHEADER;
                    tick_cnt  = '0;
                end
            end
        end
        case (seq_phase)
            PH_HEADER: begin
                len  = timing.header_period;
                mark = timing.header_mark;
            end
            PH_RHEADER: begin
                len  = timing.repeat_period;
                mark = timing.header_mark;
            end
            PH_BITS: begin
                len  = cmd_shift[31] ? timing.one_period : timing.zero_period;
                mark = timing.bit_mark;
            end
            PH_TRAILER: begin
                len  = timing.bit_mark;
                mark = timing.bit_mark;
            end
            default: ;
        endcase
        if (seq_phase != PH_IDLE) begin
            res.busy_res = 1'b1;
            res.ir_level = (tick_cnt < mark) || (seq_phase == PH_TRAILER);
            nxt = {1'b0, tick_cnt} + 17'd1;
            if (nxt >= {1'b0, len}) begin
                tick_cnt = '0;
                case (seq_phase)
                    PH_HEADER: begin
                        bit_idx   = '0;
                        seq_phase = PH_BITS;
                    end
                    PH_BITS: begin
                        cmd_shift = cmd_shift << 1;
                        bit_idx   = bit_idx + 6'd1;
                        seq_phase = (bit_idx >= CMD_BITS_DEF) ? PH_TRAILER : PH_BITS;
                    end
                    PH_RHEADER: seq_phase = PH_TRAILER;
                    default: begin
                        res.frame_done = 1'b1;
                        seq_phase      = PH_IDLE;
                    end
                endcase
            end else begin
                tick_cnt = nxt[15:0];
            end
        end
        return res;
    endfunction

    function automatic void check_bit(input string what, input logic want, input logic got);
        if (got !== want) begin
            mismatch_cnt++;
            $display("%0t: %s expected %0b actual %0b", $time, what, want, got);
        end
    endfunction

    always @(posedge clk) begin : scoreboard
        t_out_item want;
        if (rst_n && in_valid && in_ready) envelope_q.push_back(envelope_step(in_beat));
        if (rst_n && out_valid && out_ready) begin
            if (envelope_q.size() == 0) begin
                mismatch_cnt++;
                $display("%0t: unexpected beat expected none actual %b", $time, out_beat);
            end else begin
                want = envelope_q.pop_front();
                check_bit("ir_level", want.ir_level, out_beat.ir_level);
                check_bit("busy_res", want.busy_res, out_beat.busy_res);
                check_bit("frame_done", want.frame_done, out_beat.frame_done);
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int draw_wait();
        return idle_on ? int'($urandom_range(0, 13)) : 0;
    endfunction

    always begin : result_sink
        int stall;
        if (hold_cycles > 0) begin
            out_ready <= 1'b0;
            repeat (hold_cycles) @(posedge clk);
            hold_cycles = 0;
        end
        stall = draw_wait();
        if (stall > 0) begin
            out_ready <= 1'b0;
            repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
    end

    task automatic send_beat(input logic [1:0] op, input logic [31:0] word);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= t_in_item'{mode: op, command_word: word};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic run_ticks(input int n);
        repeat (n) send_beat(MODE_TICK, $urandom());
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (envelope_q.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // upper bits of the 16-bit registers carry junk, which must be dropped
    task automatic program_timing(input t_cfg c);
        put_reg(CFG_HEADER_PERIOD,   {8'($urandom()), c.header_period});
        put_reg(CFG_HEADER_MARK,     {8'($urandom()), c.header_mark});
        put_reg(CFG_BIT_MARK,        {8'($urandom()), c.bit_mark});
        put_reg(CFG_ONE_PERIOD,      {8'($urandom()), c.one_period});
        put_reg(CFG_ZERO_PERIOD,     {8'($urandom()), c.zero_period});
        put_reg(CFG_REPEAT_PERIOD,   {8'($urandom()), c.repeat_period});
        put_reg(CFG_REPEAT_INTERVAL, c.repeat_interval);
        cfg_we <= 1'b0;
        timing = c;
    endtask

    task automatic test_idle_and_defaults();
        run_ticks(3);
        send_beat(MODE_SPARE, $urandom());
        send_beat(MODE_STOP, $urandom());
        send_beat(MODE_SEND, 32'hA5C3_0F96);
        run_ticks(12);
        send_beat(MODE_STOP, $urandom());
        run_ticks(4);
    endtask

    task automatic test_frame_shapes();
        wait_drain();
        program_timing(mk_timing(3, 2, 1, 3, 2, 3, 120));
        send_beat(MODE_SEND, 32'hFFFF_FFFF);
        run_ticks(125);
        send_beat(MODE_SEND, 32'h0000_0000);
        run_ticks(30);
        send_beat(MODE_SEND, 32'h8CA0_2328);
        run_ticks(20);
        send_beat(MODE_SPARE, $urandom());
        send_beat(MODE_SPARE, $urandom());
        run_ticks(70);
        send_beat(MODE_STOP, $urandom());
        run_ticks(30);
    endtask

    task automatic test_repeat_and_stop();
        wait_drain();
        program_timing(mk_timing(4, 2, 1, 3, 2, 3, 40));
        send_beat(MODE_SEND, 32'hFFFF_0000);
        run_ticks(39);
        send_beat(MODE_SPARE, $urandom());
        send_beat(MODE_STOP, $urandom());
        run_ticks(8);
        send_beat(MODE_STOP, $urandom());
    endtask

    task automatic test_zero_timing();
        wait_drain();
        program_timing(mk_timing(0, 0, 0, 0, 0, 0, 0));
        send_beat(MODE_SEND, $urandom());
        run_ticks(40);
        wait_drain();
        program_timing(mk_timing(0, 0, 0, 0, 0, 0, 5));
        send_beat(MODE_SEND, $urandom());
        run_ticks(20);
        send_beat(MODE_STOP, $urandom());
        run_ticks(5);
    endtask

    task automatic test_mark_fills_period();
        wait_drain();
        program_timing(mk_timing(3, 9, 6, 4, 2, 2, 90));
        send_beat(MODE_SEND, $urandom());
        run_ticks(100);
        send_beat(MODE_STOP, $urandom());
        run_ticks(20);
    endtask

    task automatic test_full_scale();
        wait_drain();
        idle_on = 1'b0;
        program_timing(mk_timing(65535, 65535, 1, 2, 1, 65535, 24'hFF_FFFF));
        send_beat(MODE_SEND, $urandom());
        run_ticks(200);
        send_beat(MODE_STOP, $urandom());
        wait_drain();
        idle_on = 1'b1;
    endtask

    task automatic test_output_stall();
        wait_drain();
        program_timing(mk_timing(2, 1, 1, 3, 2, 2, 50));
        idle_on     = 1'b0;
        hold_cycles = 300;
        send_beat(MODE_SEND, $urandom());
        run_ticks(150);
        send_beat(MODE_STOP, $urandom());
        idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int          r;
        logic [1:0]  op;
        for (int s = 0; s < 5; s++) begin
            wait_drain();
            program_timing(mk_timing($urandom_range(0, 7), $urandom_range(0, 5),
                                     $urandom_range(0, 5), $urandom_range(0, 6),
                                     $urandom_range(0, 6), $urandom_range(0, 6),
                                     $urandom_range(20, 300)));
            for (int i = 0; i < 120; i++) begin
                if (i % 50 == 0) idle_on = ($urandom_range(0, 2) != 0);
                r = $urandom_range(0, 199);
                if (r < 2) op = MODE_SEND;
                else if (r < 4) op = MODE_STOP;
                else if (r < 8) op = MODE_SPARE;
                else op = MODE_TICK;
                send_beat(op, $urandom());
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        reset_sequencer();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_and_defaults();
        test_frame_shapes();
        test_repeat_and_stop();
        test_zero_timing();
        test_mark_fills_period();
        test_output_stall();
        test_full_scale();
        test_random_traffic();
        wait_drain();
        mismatch_cnt += envelope_q.size();
        if (mismatch_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
